[sv/eod_pkg.sv]
// ----------------------------------------------------------------------------
// eod_pkg
// Shared types, constants and helpers for the Easter offset date unit.
// ----------------------------------------------------------------------------
package eod_pkg;

    localparam int unsigned YEAR_W      = 14;
    localparam int unsigned OFFSET_W    = 8;
    localparam int unsigned DAY_W       = 5;
    localparam int unsigned MONTH_W     = 4;
    localparam int unsigned OPND_W      = 14;  // divider dividend / remainder width
    localparam int unsigned QUOT_W      = 10;  // widest quotient (year / 19)
    localparam int unsigned RECIP_W     = 19;  // reciprocal / divisor operand width
    localparam int unsigned RECIP_SHIFT = 20;  // reciprocals are ceil(2^20 / d)
    localparam int unsigned PROD_W      = OPND_W + RECIP_W;

    localparam logic [OFFSET_W-1:0] MAX_OFFSET = 8'd127;

    // Divisor select codes, one per division of the computus
    localparam logic [2:0] DIV_Y19  = 3'd0;  // a = y % 19
    localparam logic [2:0] DIV_Y100 = 3'd1;  // b = y / 100, c = y % 100
    localparam logic [2:0] DIV_F25  = 3'd2;  // f = (b + 8) / 25
    localparam logic [2:0] DIV_G3   = 3'd3;  // g = (b - f + 1) / 3
    localparam logic [2:0] DIV_H30  = 3'd4;  // h = (...) % 30
    localparam logic [2:0] DIV_L7   = 3'd5;  // l = (...) % 7
    localparam logic [2:0] DIV_M451 = 3'd6;  // m = (...) / 451
    localparam logic [2:0] DIV_B31  = 3'd7;  // month = base / 31, day = base % 31 + 1

    typedef struct packed {
        logic              start;
        logic [2:0]        sel;
        logic [OPND_W-1:0] dividend;
    } cdiv_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
        logic [OPND_W-1:0] rem;
    } cdiv_rsp_t;

    // ceil(2^20 / d): the error term times the largest dividend of each
    // division stays below 2^20, so the shifted product is the exact quotient
    function automatic logic [RECIP_W-1:0] div_recip(input logic [2:0] sel);
        logic [RECIP_W-1:0] r;
        unique case (sel)
            DIV_Y19:  r = 19'd55189;
            DIV_Y100: r = 19'd10486;
            DIV_F25:  r = 19'd41944;
            DIV_G3:   r = 19'd349526;
            DIV_H30:  r = 19'd34953;
            DIV_L7:   r = 19'd149797;
            DIV_M451: r = 19'd2326;
            DIV_B31:  r = 19'd33826;
        endcase
        return r;
    endfunction

    function automatic logic [RECIP_W-1:0] div_const(input logic [2:0] sel);
        logic [RECIP_W-1:0] d;
        unique case (sel)
            DIV_Y19:  d = 19'd19;
            DIV_Y100: d = 19'd100;
            DIV_F25:  d = 19'd25;
            DIV_G3:   d = 19'd3;
            DIV_H30:  d = 19'd30;
            DIV_L7:   d = 19'd7;
            DIV_M451: d = 19'd451;
            DIV_B31:  d = 19'd31;
        endcase
        return d;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic lp,
                                                   input logic [MONTH_W-1:0] mon);
        logic [DAY_W-1:0] len;
        if (mon == 4'd2) begin
            len = lp ? 5'd29 : 5'd28;
        end else if (mon == 4'd4 || mon == 4'd6 || mon == 4'd9 || mon == 4'd11) begin
            len = 5'd30;
        end else begin
            len = 5'd31;
        end
        return len;
    endfunction

endpackage

[sv/easter_offset_date_unit.sv]
// ----------------------------------------------------------------------------
// easter_offset_date_unit
// Gregorian Easter date plus a signed day offset.
// ----------------------------------------------------------------------------
// Input beats carry a year and a signed day offset; each gives one result
// beat with day, month and the leap flag of that year.
// The computus runs on one shared constant divider: each of the eight
// divisions goes through operand load, reciprocal multiply and remainder,
// and the date of Easter is loaded when the last one is done. The offset
// is then walked one day per cycle, |day_offset| days, at most 127 (-128
// counts as -127). m_tvalid rises once the divider and the day walker are
// through.
// One item is in flight at a time: s_tready is high only while idle, from
// the cycle after the result beat, so the next item waits for the receiver
// to take the result.
// The result sits in the output register with m_tvalid high until the
// receiver takes it; a stall holds it and blocks further input.
// Reset (aresetn low at a clock edge) drops any item in flight and
// returns the unit to idle with m_tvalid low.
// ----------------------------------------------------------------------------
module easter_offset_date_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [13:0] year, [21:14] day_offset, [23:22] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [4:0] day, [8:5] month, [9] leap, [15:10] zero
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_STEP = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]                      state_reg, state_next;
    logic [2:0]                      phase_reg, phase_next;
    logic [eod_pkg::YEAR_W-1:0]      year_reg, year_next;
    logic                            back_reg, back_next;
    logic [eod_pkg::OFFSET_W-1:0]    cnt_reg, cnt_next;
    logic [4:0]                      a_reg, a_next;
    logic [7:0]                      b_reg, b_next;
    logic [6:0]                      c_reg, c_next;
    logic [4:0]                      h_reg, h_next;
    logic [2:0]                      l_reg, l_next;
    logic                            leap_reg, leap_next;
    logic [eod_pkg::DAY_W-1:0]       day_reg, day_next;
    logic [eod_pkg::MONTH_W-1:0]     mon_reg, mon_next;

    eod_pkg::cdiv_req_t              div_req;
    eod_pkg::cdiv_rsp_t              div_rsp;

    logic [eod_pkg::YEAR_W-1:0]      in_year;
    logic [eod_pkg::OFFSET_W-1:0]    in_off;
    logic [eod_pkg::OFFSET_W-1:0]    in_mag;
    logic [eod_pkg::MONTH_W-1:0]     mon_prev;
    logic [eod_pkg::MONTH_W-1:0]     mon_succ;

    assign in_year  = s_tdata[13:0];
    assign in_off   = s_tdata[21:14];
    assign in_mag   = in_off[7] ? (8'd0 - in_off) : in_off;
    assign mon_prev = (mon_reg == 4'd1)  ? 4'd12 : (mon_reg - 4'd1);
    assign mon_succ = (mon_reg == 4'd12) ? 4'd1  : (mon_reg + 4'd1);

    eod_cdiv u_cdiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        year_next  = year_reg;
        back_next  = back_reg;
        cnt_next   = cnt_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        h_next     = h_reg;
        l_next     = l_reg;
        leap_next  = leap_reg;
        day_next   = day_reg;
        mon_next   = mon_reg;
        div_req    = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    year_next        = in_year;
                    back_next        = in_off[7];
                    cnt_next         = (in_mag > eod_pkg::MAX_OFFSET) ?
                                       eod_pkg::MAX_OFFSET : in_mag;
                    div_req.start    = 1'b1;
                    div_req.sel      = eod_pkg::DIV_Y19;
                    div_req.dividend = in_year;
                    phase_next       = eod_pkg::DIV_Y19;
                    state_next       = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    div_req.start = 1'b1;
                    unique case (phase_reg)
                        eod_pkg::DIV_Y19: begin
                            a_next           = div_rsp.rem[4:0];
                            div_req.sel      = eod_pkg::DIV_Y100;
                            div_req.dividend = year_reg;
                        end
                        eod_pkg::DIV_Y100: begin
                            b_next           = div_rsp.quot[7:0];
                            c_next           = div_rsp.rem[6:0];
                            // divisible by 4 and not 100, or by 400
                            leap_next        = ((year_reg[1:0] == 2'd0) &&
                                                (div_rsp.rem[6:0] != 7'd0)) ||
                                               ((div_rsp.rem[6:0] == 7'd0) &&
                                                (div_rsp.quot[1:0] == 2'd0));
                            div_req.sel      = eod_pkg::DIV_F25;
                            div_req.dividend = 14'(div_rsp.quot[7:0]) + 14'd8;
                        end
                        eod_pkg::DIV_F25: begin
                            div_req.sel      = eod_pkg::DIV_G3;
                            div_req.dividend = 14'(b_reg) - 14'(div_rsp.quot[2:0]) + 14'd1;
                        end
                        eod_pkg::DIV_G3: begin
                            div_req.sel      = eod_pkg::DIV_H30;
                            div_req.dividend = 14'(a_reg) * 14'd19 + 14'(b_reg) + 14'd315
                                               - 14'(b_reg[7:2]) - 14'(div_rsp.quot[5:0]);
                        end
                        eod_pkg::DIV_H30: begin
                            h_next           = div_rsp.rem[4:0];
                            div_req.sel      = eod_pkg::DIV_L7;
                            div_req.dividend = 14'd102 + (14'(b_reg[1:0]) << 1)
                                               + (14'(c_reg[6:2]) << 1)
                                               - 14'(div_rsp.rem[4:0]) - 14'(c_reg[1:0]);
                        end
                        eod_pkg::DIV_L7: begin
                            l_next           = div_rsp.rem[2:0];
                            div_req.sel      = eod_pkg::DIV_M451;
                            div_req.dividend = 14'(a_reg) + 14'(h_reg) * 14'd11
                                               + 14'(div_rsp.rem[2:0]) * 14'd22;
                        end
                        eod_pkg::DIV_M451: begin
                            div_req.sel      = eod_pkg::DIV_B31;
                            div_req.dividend = 14'(h_reg) + 14'(l_reg) + 14'd114
                                               - (div_rsp.quot[0] ? 14'd7 : 14'd0);
                        end
                        eod_pkg::DIV_B31: begin
                            div_req.start = 1'b0;
                            day_next      = div_rsp.rem[4:0] + 5'd1;
                            mon_next      = div_rsp.quot[3:0];
                            state_next    = (cnt_reg == 8'd0) ? ST_OUT : ST_STEP;
                        end
                    endcase
                    phase_next = div_req.sel;
                end
            end
            ST_STEP: begin
                if (back_reg) begin
                    if (day_reg == 5'd1) begin
                        mon_next = mon_prev;
                        day_next = eod_pkg::month_len(leap_reg, mon_prev);
                    end else begin
                        day_next = day_reg - 5'd1;
                    end
                end else begin
                    if (day_reg >= eod_pkg::month_len(leap_reg, mon_reg)) begin
                        mon_next = mon_succ;
                        day_next = 5'd1;
                    end else begin
                        day_next = day_reg + 5'd1;
                    end
                end
                cnt_next = cnt_reg - 8'd1;
                if (cnt_reg == 8'd1) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= eod_pkg::DIV_Y19;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
        year_reg <= year_next;
        back_reg <= back_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        h_reg    <= h_next;
        l_reg    <= l_next;
        leap_reg <= leap_next;
        day_reg  <= day_next;
        mon_reg  <= mon_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {6'd0, leap_reg, mon_reg, day_reg};

`ifndef SYNTHESIS
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while a result is pending");
    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> state_reg == ST_DIV)
        else $error("divider result outside the computus phase");
    a_step_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_STEP |-> cnt_reg != 8'd0)
        else $error("day walk with nothing left to step");
    a_date_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (mon_reg >= 4'd1) && (mon_reg <= 4'd12) && (day_reg != 5'd0))
        else $error("result date out of range");
`endif

endmodule

[sv/eod_cdiv.sv]
// ----------------------------------------------------------------------------
// eod_cdiv
// Shared divider by a selectable constant: reciprocal multiply, then remainder.
// ----------------------------------------------------------------------------
module eod_cdiv (
    input  logic               aclk,
    input  logic               aresetn,
    input  eod_pkg::cdiv_req_t req,
    output eod_pkg::cdiv_rsp_t rsp
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_REM  = 2'd2;

    logic [1:0]                      stage_reg, stage_next;
    logic                            done_reg, done_next;
    logic [2:0]                      sel_reg, sel_next;
    logic [eod_pkg::OPND_W-1:0]      num_reg, num_next;
    logic [eod_pkg::QUOT_W-1:0]      quot_reg, quot_next;
    logic [eod_pkg::OPND_W-1:0]      rem_reg, rem_next;
    logic [eod_pkg::OPND_W-1:0]      mul_a;
    logic [eod_pkg::RECIP_W-1:0]     mul_b;
    logic [eod_pkg::PROD_W-1:0]      prod;

    // one multiplier: dividend by reciprocal, then quotient by divisor
    assign mul_a = (stage_reg == ST_REM) ? 14'(quot_reg) : num_reg;
    assign mul_b = (stage_reg == ST_REM) ? eod_pkg::div_const(sel_reg)
                                         : eod_pkg::div_recip(sel_reg);
    assign prod  = 33'(mul_a) * 33'(mul_b);

    always_comb begin
        stage_next = stage_reg;
        done_next  = 1'b0;
        sel_next   = sel_reg;
        num_next   = num_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        unique case (stage_reg)
            ST_IDLE: begin
                if (req.start) begin
                    num_next   = req.dividend;
                    sel_next   = req.sel;
                    stage_next = ST_MUL;
                end
            end
            ST_MUL: begin
                quot_next  = prod[eod_pkg::RECIP_SHIFT+eod_pkg::QUOT_W-1:
                                  eod_pkg::RECIP_SHIFT];
                stage_next = ST_REM;
            end
            ST_REM: begin
                rem_next   = num_reg - prod[eod_pkg::OPND_W-1:0];
                done_next  = 1'b1;
                stage_next = ST_IDLE;
            end
            default: begin
                stage_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end else begin
            stage_reg <= stage_next;
            done_reg  <= done_next;
        end
        sel_reg  <= sel_next;
        num_reg  <= num_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

`ifndef SYNTHESIS
    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_reg != ST_IDLE) |-> !req.start)
        else $error("divider started while busy");
    a_done_after_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(stage_reg) == ST_REM)
        else $error("divider done without a finished run");
    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> 19'(rem_reg) < eod_pkg::div_const(sel_reg))
        else $error("divider remainder not below the divisor");
`endif

endmodule

[verif/tb_easter_offset_date_unit.sv]
// ----------------------------------------------------------------------------
// tb_easter_offset_date_unit
// Self-checking bench for the Easter offset date unit.
// ----------------------------------------------------------------------------
// Feeds year / day offset beats and predicts each result from an
// independent computus and day walk. Every result beat is compared with the
// oldest prediction. A directed set covers field extremes, offset
// saturation and year-end wrap. A random set follows, with both sides
// throttled at random except for one steady stretch.
// ----------------------------------------------------------------------------
module tb_easter_offset_date_unit;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int RANDOM_ITEMS   = 500;
    localparam int IDLE_PCT       = 14;
    localparam int STEADY_FIRST   = 260;  // beats inside this window see no idling
    localparam int STEADY_LAST    = 340;

    typedef struct {
        logic [eod_pkg::YEAR_W-1:0]          year;
        logic signed [eod_pkg::OFFSET_W-1:0] offset;
    } date_req_t;

    typedef struct packed {
        logic [eod_pkg::DAY_W-1:0]   day;
        logic [eod_pkg::MONTH_W-1:0] month;
        logic                        leap;
    } date_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // [13:0] year, [21:14] day_offset, [23:22] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [4:0] day, [8:5] month, [9] leap, [15:10] zero

    date_req_t pending_q[$];
    date_t     easter_dates_q[$];
    date_req_t in_flight;

    int beats_in      = 0;
    int beats_out     = 0;
    int errors        = 0;
    int leap_results  = 0;
    int clamped_items = 0;
    int idle_cycles   = 0;
    int total_cycles  = 0;

    easter_offset_date_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    function automatic int unsigned days_in_month(logic lp, int unsigned mon);
        if (mon == 2) begin
            return lp ? 29 : 28;
        end
        if (mon == 4 || mon == 6 || mon == 9 || mon == 11) begin
            return 30;
        end
        return 31;
    endfunction

    // Anonymous Gregorian computus, then a one-day-at-a-time walk
    function automatic date_t shifted_easter(date_req_t req);
        int unsigned y, a, b, c, d, e, f, g, h, i, k, l, m, base, dd, mm;
        int          steps;
        date_t       res;
        y = req.year;
        a = y % 19;
        b = y / 100;
        c = y % 100;
        d = b / 4;
        e = b % 4;
        f = (b + 8) / 25;
        g = (b - f + 1) / 3;
        h = (19 * a + b + 15 + 300 - d - g) % 30;
        i = c / 4;
        k = c % 4;
        l = (32 + 2 * e + 2 * i + 70 - h - k) % 7;
        m = (a + 11 * h + 22 * l) / 451;
        base = h + l + 114 - 7 * m;
        res.leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        dd = base % 31 + 1;
        mm = base / 31;
        steps = int'(req.offset);
        if (steps > int'(eod_pkg::MAX_OFFSET)) steps = int'(eod_pkg::MAX_OFFSET);
        if (steps < -int'(eod_pkg::MAX_OFFSET)) steps = -int'(eod_pkg::MAX_OFFSET);
        while (steps < 0) begin
            dd--;
            if (dd == 0) begin
                mm = (mm == 1) ? 12 : mm - 1;
                dd = days_in_month(res.leap, mm);
            end
            steps++;
        end
        while (steps > 0) begin
            if (dd >= days_in_month(res.leap, mm)) begin
                mm = (mm == 12) ? 1 : mm + 1;
                dd = 0;
            end
            dd++;
            steps--;
        end
        res.day   = dd[eod_pkg::DAY_W-1:0];
        res.month = mm[eod_pkg::MONTH_W-1:0];
        return res;
    endfunction

    task automatic queue_item(int unsigned year, int offset);
        date_req_t req;
        req.year   = year[eod_pkg::YEAR_W-1:0];
        req.offset = offset[eod_pkg::OFFSET_W-1:0];
        pending_q.push_back(req);
    endtask

    // Input driver: predicts at acceptance of each beat
    always @(posedge aclk) begin : driver
        logic load;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                easter_dates_q.push_back(shifted_easter(in_flight));
                if (in_flight.offset == -8'sd128) clamped_items++;
                beats_in++;
            end
            load = (!s_tvalid || s_tready) && pending_q.size() > 0 &&
                   ((beats_in >= STEADY_FIRST && beats_in < STEADY_LAST) ||
                    $urandom_range(0, 99) >= IDLE_PCT);
            if (load) begin
                in_flight = pending_q.pop_front();
                s_tdata  <= {2'b00, in_flight.offset, in_flight.year};
                s_tvalid <= 1'b1;
            end else if (s_tvalid && s_tready) begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor and back-pressure
    always @(posedge aclk) begin : monitor
        date_t want;
        date_t got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.day   = m_tdata[4:0];
                got.month = m_tdata[8:5];
                got.leap  = m_tdata[9];
                if (easter_dates_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected:", $time,
                             " day %0d month %0d leap %0b",
                             got.day, got.month, got.leap);
                    errors++;
                end else begin
                    want = easter_dates_q.pop_front();
                    if (got.day !== want.day || got.month !== want.month ||
                        got.leap !== want.leap) begin
                        $display("%0t: mismatch, expected day %0d month %0d leap %0b,",
                                 $time, want.day, want.month, want.leap,
                                 " got day %0d month %0d leap %0b",
                                 got.day, got.month, got.leap);
                        errors++;
                    end
                    if (want.leap) leap_results++;
                end
                beats_out++;
            end
            m_tready <= (beats_out >= STEADY_FIRST && beats_out < STEADY_LAST) ||
                        $urandom_range(0, 99) >= IDLE_PCT;
        end
    end

    // Stall watchdog: cycles without any beat on either side
    always @(posedge aclk) begin
        total_cycles <= total_cycles + 1;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end
        if (total_cycles >= CYCLE_LIMIT) begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int unsigned yr;
        int          off;
        int          pick;

        // field extremes and saturation
        queue_item(1583, 0);
        queue_item(9999, 0);
        queue_item(0, 0);
        queue_item(16383, 0);
        queue_item(2024, 127);
        queue_item(2024, -127);
        queue_item(2024, -128);
        queue_item(2023, -128);
        queue_item(2023, 1);
        queue_item(2023, -1);
        // leap rule: by 400, by 100, by 4
        queue_item(2000, -45);
        queue_item(1900, -45);
        queue_item(2024, -45);
        queue_item(2100, 100);
        // Easter on March 22: walk back across the year end
        queue_item(2285, -80);
        queue_item(2285, -81);
        queue_item(2285, -127);
        // Easter on April 25: far forward
        queue_item(1943, 127);
        queue_item(1943, 36);
        queue_item(10000, -128);
        queue_item(8191, 64);
        queue_item(5461, -86);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                yr = $urandom_range(1583, 9999);
            end else begin
                yr = $urandom_range(0, 16383);
            end
            pick = $urandom_range(0, 7);
            if (pick == 0) begin
                off = $urandom_range(0, 1) ? 127 : -128;
            end else if (pick == 1) begin
                off = int'($urandom_range(0, 20)) - 10;
            end else begin
                off = int'($urandom_range(0, 255)) - 128;
            end
            queue_item(yr, off);
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_q.size() != 0 || s_tvalid || easter_dates_q.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Checked %0d date results from %0d input beats.", beats_out, beats_in);
        $display("Leap-year results: %0d, offsets of -128 clamped: %0d.",
                 leap_results, clamped_items);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", errors);
            $display("status: fail");
        end
        $finish;
    end

endmodule
